/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

/* rtl/core/osrs_pkg.sv */
// Package for the ordered set with range sum: constants, types, states.
// No dependencies.
package osrs_pkg;
    localparam int CAPACITY = 256;
    localparam int KEY_BITS = 32;
    localparam int SUM_BITS = 40;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int IN_W = 72;
    localparam int OUT_W = 56;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [SUM_BITS-1:0] sum_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_RANGE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic ins_en;
        logic del_en;
        logic sum_en;
        key_t k;
        key_t lo;
        key_t hi;
    } cell_ctl_t;

    typedef struct packed {
        logic [8:0] entry_count;
        logic       full_drop;
        sum_t       range_total;
        logic       present;
    } result_t;
endpackage

/* rtl/core/ordered_set_range_sum.sv */
// Top level of the ordered set with range sum: handshake, control, cell chain.
// Depends on osrs_pkg and osrs_cell.
//
// Input channel s_*: one item per request (operation, key, upper_key).
// Output channel m_*: one result item per request.
// Insert and delete update the chain at the accepting edge, find only reads
// it; the result moves from the pending to the output register once that is free.
// Range sum passes a partial sum down the chain of CAPACITY cells, one cell
// per cycle; ST_FINISH then loads its result into the pending register.
// A new request is accepted only in ST_IDLE with the pending register empty,
// so no request is taken while a range sum sweeps or a result is pending.
// A pending stage behind the output register lets one item be accepted
// while a result waits; with both full, s_tready stays low.
// Reset empties the set and drops any results in flight.
// A stalled receiver holds m_tdata steady until m_tready.
// Insert into a full store is refused and flagged with full_drop.
module ordered_set_range_sum (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // operation[1:0], key[33:2], upper_key[65:34], zero pad
    input  logic [osrs_pkg::IN_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // present[0], range_total[40:1], full_drop[41], entry_count[50:42], zero pad
    output logic [osrs_pkg::OUT_W-1:0] m_tdata
);
    import osrs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic [IDX_W-1:0] sweep_reg;
    logic [IDX_W-1:0] sweep_next;
    cnt_t count_reg;
    cnt_t count_next;
    key_t lo_reg;
    key_t hi_reg;
    logic pend_valid_reg;
    result_t pend_reg;
    logic out_valid_reg;
    result_t out_reg;

    op_t in_op;
    key_t in_key;
    key_t in_upper;
    logic accept;
    logic hit;
    logic full;
    logic pend_load;
    result_t pend_value;
    logic move;
    cell_ctl_t ctl;

    key_t cell_key [CAPACITY];
    logic cell_lt [CAPACITY];
    logic [CAPACITY-1:0] cell_eq;
    sum_t cell_sum [CAPACITY];

    assign in_op = op_t'(s_tdata[1:0]);
    assign in_key = s_tdata[33:2];
    assign in_upper = s_tdata[65:34];
    assign accept = s_tvalid && s_tready;
    assign hit = |cell_eq;
    assign full = (count_reg == cnt_t'(CAPACITY));
    assign move = pend_valid_reg && (!out_valid_reg || m_tready);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic valid_i;
            key_t left_key_i;
            logic left_lt_i;
            key_t right_key_i;
            sum_t left_sum_i;
            assign valid_i = (count_reg > cnt_t'(gi));
            if (gi == 0)
            begin : g_first
                assign left_key_i = in_key;
                assign left_lt_i = 1'b0;
                assign left_sum_i = '0;
            end
            else
            begin : g_mid
                assign left_key_i = cell_key[gi-1];
                assign left_lt_i = cell_lt[gi-1];
                assign left_sum_i = cell_sum[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_key_i = cell_key[gi];
            end
            else
            begin : g_inner
                assign right_key_i = cell_key[gi+1];
            end
            osrs_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .valid     (valid_i),
                .left_key  (left_key_i),
                .left_lt   (left_lt_i),
                .right_key (right_key_i),
                .left_sum  (left_sum_i),
                .key       (cell_key[gi]),
                .lt        (cell_lt[gi]),
                .eq        (cell_eq[gi]),
                .sum       (cell_sum[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_op == OP_RANGE)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        ctl.ins_en = 1'b0;
        ctl.del_en = 1'b0;
        ctl.sum_en = 1'b0;
        ctl.k = in_key;
        ctl.lo = lo_reg;
        ctl.hi = hi_reg;
        pend_load = 1'b0;
        pend_value = '0;
        count_next = count_reg;
        sweep_next = sweep_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = !pend_valid_reg;
                sweep_next = '0;
                if (accept && in_op != OP_RANGE)
                begin
                    pend_load = 1'b1;
                    pend_value.present = hit;
                    if (in_op == OP_INSERT && !hit)
                    begin
                        if (full)
                        begin
                            pend_value.full_drop = 1'b1;
                        end
                        else
                        begin
                            ctl.ins_en = 1'b1;
                            count_next = count_reg + cnt_t'(1);
                        end
                    end
                    else if (in_op == OP_DELETE && hit)
                    begin
                        ctl.del_en = 1'b1;
                        count_next = count_reg - cnt_t'(1);
                    end
                end
            end
            ST_SWEEP:
            begin
                ctl.sum_en = 1'b1;
                sweep_next = sweep_reg + IDX_W'(1);
            end
            ST_FINISH:
            begin
                pend_load = 1'b1;
                pend_value.range_total = cell_sum[CAPACITY-1];
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        pend_value.entry_count = 9'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sweep_reg <= '0;
            count_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            count_reg <= count_next;
            if (pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg <= in_key;
            hi_reg <= in_upper;
        end
        if (pend_load)
        begin
            pend_reg <= pend_value;
        end
        if (move)
        begin
            out_reg <= pend_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = OUT_W'(out_reg);

    `include "assert_macros.svh"
    `ASSERT_NEVER(a_cnt_max, count_reg > cnt_t'(CAPACITY), "count above capacity")
    `ASSERT_NEVER(a_pend_rdy, pend_valid_reg && s_tready, "ready with pending result")
    `ASSERT_NEVER(a_load_busy, pend_load && pend_valid_reg, "pending result overwritten")
    `ASSERT_CLK(a_cnt_hold, state_reg != ST_IDLE |=> count_reg == $past(count_reg), "count moved")
endmodule

/* rtl/core/osrs_cell.sv */
// One slot of the sorted chain: holds a key and a running range-sum stage.
// Depends on osrs_pkg.
module osrs_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  osrs_pkg::cell_ctl_t ctl,
    input  logic               valid,
    input  osrs_pkg::key_t     left_key,
    input  logic               left_lt,
    input  osrs_pkg::key_t     right_key,
    input  osrs_pkg::sum_t     left_sum,
    output osrs_pkg::key_t     key,
    output logic               lt,
    output logic               eq,
    output osrs_pkg::sum_t     sum
);
    import osrs_pkg::*;

    key_t key_reg;
    key_t key_next;
    sum_t sum_reg;
    sum_t sum_next;
    logic in_range;

    assign key = key_reg;
    assign sum = sum_reg;
    assign lt = valid && (key_reg < ctl.k);
    assign eq = valid && (key_reg == ctl.k);
    assign in_range = valid && (key_reg >= ctl.lo) && (key_reg <= ctl.hi);

    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins_en && !lt)
        begin
            key_next = left_lt ? ctl.k : left_key;
        end
        else if (ctl.del_en && !lt)
        begin
            key_next = right_key;
        end
    end

    always_comb
    begin
        sum_next = left_sum + (in_range ? sum_t'(key_reg) : '0);
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (ctl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_NEVER(a_ins_del, ctl.ins_en && ctl.del_en, "insert and delete together")
    `ASSERT_NEVER(a_sum_upd, ctl.sum_en && (ctl.ins_en || ctl.del_en), "store moved in sweep")
    `ASSERT_CLK(a_hold, !ctl.ins_en && !ctl.del_en |=> key_reg === $past(key_reg), "key moved")
endmodule
